### sv/greedy_lowest_neighbor_path_assert.svh
// Assertion macros for the greedy lowest-neighbor path block.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef GREEDY_LOWEST_NEIGHBOR_PATH_ASSERT_SVH
`define GREEDY_LOWEST_NEIGHBOR_PATH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLNP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GLNP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/glnp_pkg.sv
// Shared types, sizes and helpers of the greedy lowest-neighbor path block.
// No dependencies; imported by glnp_step and the top level.
package glnp_pkg;

  localparam int MAX_ROWS    = 512;
  localparam int MAX_COLS    = 1024;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int NCOL_W      = $clog2(MAX_COLS + 1);

  localparam int ELEV_W      = 16;
  localparam int TOTAL_W     = 31;
  localparam int SEED_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [SEED_W-1:0]  LFSR_MASK = 16'hB400;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIE_SEED  = 2'd2;

  typedef struct packed {
    logic signed [ELEV_W-1:0] elevation;
    logic                     last_sample;
  } in_item_t;

  typedef struct packed {
    logic [8:0]         best_row;
    logic [TOTAL_W-1:0] best_total;
  } out_item_t;

  // Outcome of one column step
  typedef struct packed {
    logic                     go_up;
    logic                     go_dn;
    logic                     tie_used;
    logic signed [ELEV_W-1:0] pick;
    logic [ELEV_W-1:0]        delta;
  } step_res_t;

  // Index of the last row in use, rows clamped to [2, MAX_ROWS]
  function automatic logic [ROW_W-1:0] last_row_of(logic [9:0] rows);
    logic [31:0] r;
    r = 32'(rows);
    if (r < 32'd2) r = 32'd2;
    else if (r > 32'(MAX_ROWS)) r = 32'(MAX_ROWS);
    return ROW_W'(r - 32'd1);
  endfunction

  // Columns in use, clamped to [2, MAX_COLS]
  function automatic logic [NCOL_W-1:0] ncols_of(logic [10:0] cols);
    logic [31:0] c;
    c = 32'(cols);
    if (c < 32'd2) c = 32'd2;
    else if (c > 32'(MAX_COLS)) c = 32'(MAX_COLS);
    return NCOL_W'(c);
  endfunction

  function automatic logic [SEED_W-1:0] lfsr_step(logic [SEED_W-1:0] s);
    return {1'b0, s[SEED_W-1:1]} ^ (s[0] ? LFSR_MASK : '0);
  endfunction

endpackage

### sv/glnp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module glnp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/glnp_step.sv
// Neighbor choice for one column step: picks the lowest forward neighbor,
// settles ties, and gives the absolute elevation change. Uses glnp_pkg.
module glnp_step import glnp_pkg::*; (
  input  logic signed [ELEV_W-1:0] here,
  input  logic signed [ELEV_W-1:0] st,
  input  logic signed [ELEV_W-1:0] up,
  input  logic signed [ELEV_W-1:0] dn,
  input  logic                     has_up,
  input  logic                     has_dn,
  input  logic                     tie_bit,
  output step_res_t                res
);

  logic signed [ELEV_W:0] diff;
  logic        [ELEV_W:0] mag;

  always_comb begin
    res          = '0;
    res.pick     = st;
    if (has_up && has_dn) begin
      if (up < st && up < dn) begin
        res.go_up = 1'b1;
        res.pick  = up;
      end else if (up == dn && dn < st) begin
        // up/down tie below straight: LFSR bit picks the side
        res.tie_used = 1'b1;
        res.pick     = dn;
        res.go_up    = tie_bit;
        res.go_dn    = !tie_bit;
      end else if (dn < up && dn < st) begin
        res.go_dn = 1'b1;
        res.pick  = dn;
      end
    end else if (has_up) begin
      if (up < st) begin
        res.go_up = 1'b1;
        res.pick  = up;
      end
    end else if (has_dn) begin
      if (dn < st) begin
        res.go_dn = 1'b1;
        res.pick  = dn;
      end
    end
    diff      = {res.pick[ELEV_W-1], res.pick} - {here[ELEV_W-1], here};
    mag       = diff[ELEV_W] ? (ELEV_W+1)'(0) - diff : diff;
    res.delta = mag[ELEV_W-1:0];
  end

endmodule

### sv/greedy_lowest_neighbor_path.sv
// Greedy lowest-neighbor path search: top level with load and search control.
// Depends on glnp_pkg, glnp_ram, glnp_step and the assertion macro header.
//
// Use:
//   in_*  : grid samples in row-major order, one transfer per cycle while
//           loading. The transfer with last_sample set starts the search;
//           in_stall stays high until the result goes to the output register.
//   out_* : one transfer per grid: best_row and best_total. A result waits
//           in the output register while out_stall is high; loading of the
//           next grid goes on meanwhile, and only a finished next search
//           waits for the register to free up.
//   cfg_* : register writes, always ready; index 0 rows_used, 1 cols_used,
//           2 tie_seed. Write only while the block is idle.
// Search: the grid sits in one RAM with one read port, so each path first
//   reads its start cell (S_PSTART) and then, per column, the straight, up
//   and down neighbors (S_RD_ST, S_RD_UP, S_RD_DN), then chooses (S_DECIDE).
//   S_PEND compares the path's total with the best; S_DONE outputs the best.
// Reset: synchronous, active low. Clears control and configuration to
//   512 rows, 1024 columns, seed 1. The grid RAM is not cleared.
`include "greedy_lowest_neighbor_path_assert.svh"

module greedy_lowest_neighbor_path import glnp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [8:0] {
    S_LOAD   = 9'b000000001,
    S_INIT   = 9'b000000010,
    S_PSTART = 9'b000000100,  // issue read of the path's first cell
    S_RD_ST  = 9'b000001000,  // issue straight read
    S_RD_UP  = 9'b000010000,  // issue up-diagonal read
    S_RD_DN  = 9'b000100000,  // issue down-diagonal read
    S_DECIDE = 9'b001000000,  // choose and move
    S_PEND   = 9'b010000000,  // path done: compare with best
    S_DONE   = 9'b100000000   // hand result to output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [9:0]         rows_used_r;
  logic [10:0]        cols_used_r;
  logic [SEED_W-1:0]  tie_seed_r;

  // search context
  logic [ROW_W-1:0]   last_row_r;
  logic [NCOL_W-1:0]  ncols_r;
  logic [SEED_W-1:0]  seed_r;
  logic [ADDR_W-1:0]  load_addr_r;
  logic [ROW_W-1:0]   start_row_r;
  logic [ADDR_W-1:0]  start_base_r;
  logic [ROW_W-1:0]   path_row_r;
  logic [ADDR_W-1:0]  row_base_r;
  logic [COL_W-1:0]   col_r;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TOTAL_W-1:0] least_total_r;
  logic [ROW_W-1:0]   least_row_r;
  logic [SEED_W-1:0]  lfsr_r;
  logic               first_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r;

  logic signed [ELEV_W-1:0] here_r, st_r, up_r;

  logic                in_fire;
  logic [ADDR_W-1:0]   st_addr, rd_addr;
  logic [ELEV_W-1:0]   rd_data;
  logic                has_up, has_dn, last_step;
  logic [TOTAL_W:0]    sum;
  step_res_t           step;
  logic [ADDR_W-1:0]   ncols_ext;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != S_LOAD);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ncols_ext = ADDR_W'(ncols_r);
  assign st_addr   = row_base_r + ADDR_W'(col_r) + ADDR_W'(1);
  assign has_up    = (path_row_r != '0);
  assign has_dn    = (path_row_r != last_row_r);
  assign last_step = ({1'b0, col_r} + NCOL_W'(1)) == (ncols_r - NCOL_W'(1));

  always_comb begin
    unique case (state_r)
      S_PSTART: rd_addr = start_base_r;
      S_RD_UP:  rd_addr = st_addr - ncols_ext;
      S_RD_DN:  rd_addr = st_addr + ncols_ext;
      default:  rd_addr = st_addr;
    endcase
  end

  glnp_ram #(
    .WIDTH (ELEV_W),
    .DEPTH (STORE_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_addr_r),
    .wdata (in_data.elevation),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // rd_data holds the down-diagonal cell while in S_DECIDE
  glnp_step u_step (
    .here    (here_r),
    .st      (st_r),
    .up      (up_r),
    .dn      (rd_data),
    .has_up  (has_up),
    .has_dn  (has_dn),
    .tie_bit (lfsr_r[0]),
    .res     (step)
  );

  assign sum       = {1'b0, total_r} + (TOTAL_W + 1)'(step.delta);
  assign total_nxt = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_LOAD:   if (in_fire && in_data.last_sample) state_nxt = S_INIT;
      S_INIT:   state_nxt = S_PSTART;
      S_PSTART: state_nxt = S_RD_ST;
      S_RD_ST:  state_nxt = S_RD_UP;
      S_RD_UP:  state_nxt = S_RD_DN;
      S_RD_DN:  state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = last_step ? S_PEND : S_RD_ST;
      S_PEND:   state_nxt = (start_row_r == last_row_r) ? S_DONE : S_PSTART;
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_LOAD;
        end
      end
      default:  state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_LOAD;
      out_valid_r   <= 1'b0;
      rows_used_r   <= 10'd512;
      cols_used_r   <= 11'd1024;
      tie_seed_r    <= 16'd1;
      load_addr_r   <= '0;
      start_row_r   <= '0;
      start_base_r  <= '0;
      path_row_r    <= '0;
      row_base_r    <= '0;
      col_r         <= '0;
      total_r       <= '0;
      least_total_r <= TOTAL_MAX;
      least_row_r   <= '0;
      lfsr_r        <= 16'd1;
      first_r       <= 1'b0;
      last_row_r    <= '0;
      ncols_r       <= '0;
      seed_r        <= 16'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROWS_USED: rows_used_r <= cfg_data[9:0];
          CFG_COLS_USED: cols_used_r <= cfg_data[10:0];
          CFG_TIE_SEED:  tie_seed_r  <= cfg_data;
          default: ;
        endcase
      end

      if (in_fire) begin
        if (in_data.last_sample || load_addr_r == ADDR_W'(STORE_DEPTH - 1)) begin
          load_addr_r <= '0;
        end else begin
          load_addr_r <= load_addr_r + ADDR_W'(1);
        end
      end

      unique case (state_r)
        S_INIT: begin
          last_row_r    <= last_row_of(rows_used_r);
          ncols_r       <= ncols_of(cols_used_r);
          seed_r        <= (tie_seed_r == '0) ? 16'd1 : tie_seed_r;
          least_total_r <= TOTAL_MAX;
          least_row_r   <= '0;
          start_row_r   <= '0;
          start_base_r  <= '0;
        end
        S_PSTART: begin
          path_row_r <= start_row_r;
          row_base_r <= start_base_r;
          col_r      <= '0;
          total_r    <= '0;
          lfsr_r     <= seed_r;
          first_r    <= 1'b1;
        end
        S_RD_ST: first_r <= 1'b0;
        S_DECIDE: begin
          total_r <= total_nxt;
          col_r   <= col_r + COL_W'(1);
          if (step.tie_used) lfsr_r <= lfsr_step(lfsr_r);
          if (step.go_up) begin
            path_row_r <= path_row_r - ROW_W'(1);
            row_base_r <= row_base_r - ncols_ext;
          end else if (step.go_dn) begin
            path_row_r <= path_row_r + ROW_W'(1);
            row_base_r <= row_base_r + ncols_ext;
          end
        end
        S_PEND: begin
          if (total_r < least_total_r) begin
            least_total_r <= total_r;
            least_row_r   <= start_row_r;
          end
          start_row_r  <= start_row_r + ROW_W'(1);
          start_base_r <= start_base_r + ncols_ext;
        end
        default: ;
      endcase
    end
  end

  // Sample pipeline from the RAM read port, plus the output register
  always_ff @(posedge clk) begin
    if (state_r == S_RD_ST && first_r) here_r <= rd_data;
    if (state_r == S_DECIDE)          here_r <= step.pick;
    if (state_r == S_RD_UP)           st_r   <= rd_data;
    if (state_r == S_RD_DN)           up_r   <= rd_data;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r.best_row   <= 9'(least_row_r);
      out_data_r.best_total <= least_total_r;
    end
  end

  `GLNP_ASSERT_NOW(a_row_in_grid, state_r == S_DECIDE, path_row_r <= last_row_r, "path row beyond last row")
  `GLNP_ASSERT_NOW(a_start_in_grid, state_r == S_PEND, start_row_r <= last_row_r, "start row beyond last row")
  `GLNP_ASSERT_NEXT(a_last_starts, in_fire && in_data.last_sample, state_r == S_INIT && load_addr_r == '0, "last sample did not start search")

endmodule

### sim/tb_greedy_lowest_neighbor_path.sv
// Self-checking testbench for greedy_lowest_neighbor_path: loads elevation grids, runs
// searches and compares every best_row/best_total transfer against a built-in predictor.
// Depends on glnp_pkg and the block's RTL only.
module tb_greedy_lowest_neighbor_path;
  import glnp_pkg::*;

  // Several times the slowest correct run: about 420 samples and a few dozen
  // searches over grids of at most 8x8.
  localparam int CYCLE_LIMIT    = 200_000;
  localparam int RANDOM_SAMPLES = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int REPORT_LIMIT   = 10;

  // Index 3 is not decoded by the block; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {ELEV_FULL, ELEV_NARROW, ELEV_EXTREME} elev_mode_e;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  greedy_lowest_neighbor_path i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a mirror of the grid RAM, the load pointer and the three
  // registers as last written. filled tracks how far from address 0 the RAM
  // has been written since reset, so short grids never read a blank cell.
  // ---------------------------------------------------------------------------
  logic [ELEV_W-1:0] elev_mirror [STORE_DEPTH];
  int                load_ptr;
  int                filled;
  logic [9:0]        rows_reg;
  logic [10:0]       cols_reg;
  logic [SEED_W-1:0] seed_reg;

  out_item_t routes_due [$];   // predicted search results, oldest first

  bit idle_on;                 // random gaps on input and stalls on output
  int mismatches;
  int samples_sent;
  int grids_checked;
  int lfsr_ties;
  int cycle_count;

  // Rows and columns as the search sees them, clamped to the legal range.
  function automatic int used_rows();
    int r;
    r = rows_reg;
    return (r < 2) ? 2 : (r > MAX_ROWS) ? MAX_ROWS : r;
  endfunction

  function automatic int used_cols();
    int c;
    c = cols_reg;
    return (c < 2) ? 2 : (c > MAX_COLS) ? MAX_COLS : c;
  endfunction

  function automatic int elev_at(int r, int c, int ncols);
    return int'($signed(elev_mirror[(r * ncols + c) % STORE_DEPTH]));
  endfunction

  // Trace one greedy path per start row over the mirrored grid and keep the
  // first row with the smallest saturated total.
  function automatic out_item_t lowest_route();
    out_item_t         res;
    int                nrows, ncols, row, nxt, here, st, up, dn, pick;
    bit                has_up, has_dn;
    longint            total, best;
    logic [SEED_W-1:0] lfsr;
    nrows = used_rows();
    ncols = used_cols();
    best = longint'(TOTAL_MAX);
    res.best_row = '0;
    for (int start = 0; start < nrows; start++) begin
      lfsr = (seed_reg == '0) ? SEED_W'(1) : seed_reg;
      row = start;
      total = 0;
      for (int col = 0; col + 1 < ncols; col++) begin
        here = elev_at(row, col, ncols);
        st = elev_at(row, col + 1, ncols);
        pick = st;
        nxt = row;
        has_up = (row > 0);
        has_dn = (row + 1 < nrows);
        up = has_up ? elev_at(row - 1, col + 1, ncols) : 0;
        dn = has_dn ? elev_at(row + 1, col + 1, ncols) : 0;
        if (has_up && has_dn) begin
          if (up < st && up < dn) begin
            nxt = row - 1;
            pick = up;
          end else if (up == dn && dn < st) begin
            // both diagonals equal and below straight: LFSR bit 0 picks
            pick = dn;
            nxt = lfsr[0] ? row - 1 : row + 1;
            lfsr = {1'b0, lfsr[SEED_W-1:1]} ^ (lfsr[0] ? LFSR_MASK : '0);
            lfsr_ties++;
          end else if (dn < up && dn < st) begin
            nxt = row + 1;
            pick = dn;
          end
        end else if (has_up) begin
          if (up < st) begin
            nxt = row - 1;
            pick = up;
          end
        end else if (has_dn) begin
          if (dn < st) begin
            nxt = row + 1;
            pick = dn;
          end
        end
        total += (pick > here) ? pick - here : here - pick;
        if (total > longint'(TOTAL_MAX)) total = longint'(TOTAL_MAX);
        row = nxt;
      end
      if (total < best) begin
        best = total;
        res.best_row = 9'(start);
      end
    end
    res.best_total = best[TOTAL_W-1:0];
    return res;
  endfunction

  function automatic logic [ELEV_W-1:0] draw_elevation(elev_mode_e mode);
    int v;
    case (mode)
      ELEV_NARROW: begin
        // tiny range, so ties of every kind are common
        v = int'($urandom_range(0, 4)) - 2;
        return ELEV_W'(v);
      end
      ELEV_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return ELEV_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side. Inputs change only by nonblocking assignment right after a
  // rising edge; handshakes are sampled at the edge, before any update lands.
  // ---------------------------------------------------------------------------

  // One sample transfer. The mirror and the load pointer follow the block's
  // behavior once the transfer has happened; a last sample queues a result.
  task automatic send_sample(input logic [ELEV_W-1:0] elev, input logic last);
    in_item_t item;
    item.elevation = elev;
    item.last_sample = last;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    elev_mirror[load_ptr] = elev;
    if (load_ptr + 1 > filled) filled = load_ptr + 1;
    load_ptr = (load_ptr + 1) % STORE_DEPTH;
    samples_sent++;
    if (last) begin
      routes_due.push_back(lowest_route());
      load_ptr = 0;
    end
  endtask

  task automatic send_grid(input int len, input elev_mode_e mode);
    for (int i = 0; i < len; i++) send_sample(draw_elevation(mode), i == len - 1);
  endtask

  // Register write; the block is idle whenever this runs.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_ROWS_USED: rows_reg = val[9:0];
      CFG_COLS_USED: cols_reg = val[10:0];
      CFG_TIE_SEED:  seed_reg = val[SEED_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid_shape(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols,
                                input logic [CFG_DATA_W-1:0] seed);
    write_reg(CFG_ROWS_USED, rows);
    write_reg(CFG_COLS_USED, cols);
    write_reg(CFG_TIE_SEED, seed);
  endtask

  // Drop valid, wait for every predicted result, then let the block go quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (routes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-built 3x3 grids with the seed left at its reset value:
  //  grid A - full-scale extremes; from the middle row both diagonals tie
  //           below straight, so the LFSR decides; edge rows first go straight.
  //  grid B - flat grid, every choice ties with straight, all totals zero,
  //           so the first row wins.
  //  grid C - last sample after four cells; the rest keep grid B's values.
  task automatic test_directed();
    logic [ELEV_W-1:0] grid_a [9];
    grid_a = '{16'h8000, 16'h0000, 16'h7FFF,
               16'h7FFF, 16'd100,  16'h0000,
               16'h0000, 16'h0000, 16'h8000};
    write_reg(CFG_ROWS_USED, 16'd3);
    write_reg(CFG_COLS_USED, 16'd3);
    for (int i = 0; i < 9; i++) send_sample(grid_a[i], i == 8);
    for (int i = 0; i < 9; i++) send_sample(16'd7, i == 8);
    for (int i = 0; i < 4; i++) send_sample(draw_elevation(ELEV_NARROW), i == 3);
    drain_results();
  endtask

  // Register sweep on small shapes: the smallest legal shape, values below
  // the range that clamp, junk in the unused data bits, a zero seed and a
  // write to the undecoded index.
  task automatic test_register_extremes();
    logic [CFG_DATA_W-1:0] rows_set [7];
    logic [CFG_DATA_W-1:0] cols_set [7];
    logic [CFG_DATA_W-1:0] seed_set [7];
    rows_set = '{16'd2,    16'hFC03, 16'd0,    16'd1,    16'd2,    16'h0402, 16'd5};
    cols_set = '{16'd2,    16'hF803, 16'd1,    16'd0,    16'h0804, 16'd2,    16'd3};
    seed_set = '{16'hFFFF, 16'd0,    16'h8000, 16'h0001, 16'hACE1, 16'h0000, 16'h5A5A};
    for (int i = 0; i < 7; i++) begin
      set_grid_shape(rows_set[i], cols_set[i], seed_set[i]);
      if (i == 0) write_reg(CFG_SPARE, 16'hFFFF);
      send_grid(used_rows() * used_cols(), elev_mode_e'($urandom_range(0, 2)));
      drain_results();
    end
  endtask

  // Random shapes and seeds. Most grids are complete; some end early (only
  // over cells already written) and some run past the used area.
  task automatic test_random_grids();
    int first, cells, len;
    first = samples_sent;
    while (samples_sent - first < RANDOM_SAMPLES) begin
      set_grid_shape(16'($urandom_range(2, 8)), 16'($urandom_range(2, 8)),
                     ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)));
      repeat ($urandom_range(1, 3)) begin
        cells = used_rows() * used_cols();
        len = cells;
        case ($urandom_range(0, 9))
          0: if (filled >= cells) len = $urandom_range(1, cells - 1);
          1: len = cells + $urandom_range(1, 6);
          default: ;
        endcase
        send_grid(len, elev_mode_e'($urandom_range(0, 2)));
      end
      drain_results();
    end
  endtask

  // Several grids in a row without any idling on either side.
  task automatic test_back_to_back();
    idle_on = 1'b0;
    set_grid_shape(16'd3, 16'd4, 16'($urandom_range(1, 65535)));
    for (int g = 0; g < 4; g++) send_grid(12, elev_mode_e'($urandom_range(0, 2)));
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, and a compare of every result transfer
  // with the oldest prediction.
  // ---------------------------------------------------------------------------
  int hold_left;
  always @(posedge clk) begin
    if (!idle_on) hold_left = 0;
    else if (hold_left > 0) hold_left = hold_left - 1;
    else if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(1, 5);
    out_stall <= (hold_left > 0);
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin : check_routes
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (routes_due.size() == 0) begin
        note_mismatch($sformatf("result with none pending: row %0d total %0d",
                                out_data.best_row, out_data.best_total));
      end else begin
        want = routes_due.pop_front();
        if (out_data.best_row !== want.best_row)
          note_mismatch($sformatf("best_row expected %0d got %0d",
                                  want.best_row, out_data.best_row));
        if (out_data.best_total !== want.best_total)
          note_mismatch($sformatf("best_total expected %0d got %0d",
                                  want.best_total, out_data.best_total));
        grids_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, routes_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    mismatches = 0;
    samples_sent = 0;
    grids_checked = 0;
    lfsr_ties = 0;
    load_ptr = 0;
    filled = 0;
    rows_reg = 10'd512;
    cols_reg = 11'd1024;
    seed_reg = 16'd1;
    idle_on = 1'b1;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_ROWS_USED;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_random_grids();
    test_back_to_back();

    $display("covered %0d samples, %0d searches checked, %0d diagonal ties settled by the LFSR",
             samples_sent, grids_checked, lfsr_ties);
    $display("shapes from 2x2 to 8x8, clamped and junk register values, short and long grids");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/glnp_pkg.sv
sv/glnp_ram.sv
sv/glnp_step.sv
sv/greedy_lowest_neighbor_path.sv
sim/tb_greedy_lowest_neighbor_path.sv
